### rtl/vsp_pkg.sv
// ============================================================================
// vsp_pkg: shared types and constants of the voice slot pool
// Operation and status codes, register indexes, the configuration bundle and
// the result bundle that pass between the sequencer and the top level.
// ============================================================================
package vsp_pkg;

    localparam int ID_W        = 32;
    localparam int LIMIT_W     = 8;
    localparam int COUNT_W     = 8;
    localparam int SLOT_IDX_W  = 7;
    localparam int CLASS_IDX_W = 2;
    localparam int NUM_LIMITS  = 3;

    localparam logic [ID_W-1:0]    ID_ALL_ONES  = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd128;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        STS_OK            = 3'd0,
        STS_BAD_CLASS     = 3'd1,
        STS_FULL          = 3'd2,
        STS_NOT_FOUND     = 3'd3,
        STS_EMPTY_IGNORED = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_EMPTY_MARKER = 2'd0,
        REG_LIMIT0       = 2'd1,
        REG_LIMIT1       = 2'd2,
        REG_LIMIT2       = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        FSM_CLEAR,
        FSM_IDLE,
        FSM_SCAN,
        FSM_WRITE,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic [ID_W-1:0]                     empty_marker;
        logic [NUM_LIMITS-1:0][LIMIT_W-1:0]  limit;
    } vsp_cfg_t;

    typedef struct packed {
        status_t                  status;
        logic                     has_space;
        logic [COUNT_W-1:0]       class_count;
        logic [SLOT_IDX_W-1:0]    slot_index;
        logic [CLASS_IDX_W-1:0]   hit_class;
    } vsp_result_t;

endpackage

### rtl/vsp_slot_mem.sv
// ============================================================================
// vsp_slot_mem: identifier slot storage
// One write port and one read port with registered read data.
// ============================================================================
module vsp_slot_mem
    import vsp_pkg::*;
#(
    parameter int DEPTH  = 384,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ID_W-1:0]   wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ID_W-1:0]   rd_data
);

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/vsp_seq.sv
// ============================================================================
// vsp_seq: slot pool sequencer
// Clears the slot memory after reset, then runs each add or remove by walking
// the slots one read per cycle through a single shared identifier comparator.
// ============================================================================
module vsp_seq
    import vsp_pkg::*;
#(
    parameter int SLOTS   = 128,
    parameter int CLASSES = 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  vsp_cfg_t      cfg,
    input  logic          item_valid,
    input  logic [1:0]    op,
    input  logic [1:0]    pool_class,
    input  logic [ID_W-1:0] sound_id,
    output logic          busy,
    input  logic          res_ready,
    output logic          res_valid,
    output vsp_result_t   result
);

    localparam int DEPTH   = CLASSES * SLOTS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOTC_W = $clog2(SLOTS + 1);
    localparam int CLASS_W = (CLASSES > 1) ? $clog2(CLASSES) : 1;
    localparam int CMP_W   = (SLOTC_W > LIMIT_W) ? SLOTC_W : LIMIT_W;

    fsm_t                 state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    op_t                  op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [CLASS_W-1:0]   work_class_reg, work_class_next;
    logic [CLASS_W-1:0]   last_class_reg, last_class_next;
    logic [CLASS_W-1:0]   cur_class_reg, cur_class_next;
    logic [SLOTC_W-1:0]   cur_slot_reg, cur_slot_next;
    logic                 iter_active_reg, iter_active_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [CLASS_W-1:0]   pend_class_reg, pend_class_next;
    logic [SLOT_W-1:0]    pend_slot_reg, pend_slot_next;
    logic [ADDR_W-1:0]    pend_addr_reg, pend_addr_next;
    status_t              res_status_reg, res_status_next;
    logic [SLOT_IDX_W-1:0]  res_slot_reg, res_slot_next;
    logic [CLASS_IDX_W-1:0] res_hit_reg, res_hit_next;
    logic                 count_valid_reg, count_valid_next;
    logic [COUNT_W-1:0]   counts_reg [CLASSES];
    logic [COUNT_W-1:0]   counts_next [CLASSES];

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ID_W-1:0]      mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    scan_addr;
    logic [ID_W-1:0]      mem_rdata;
    logic [ID_W-1:0]      match_key;
    logic                 match;
    logic                 bad_class;
    logic [COUNT_W-1:0]   count_rd;

    // True when value v lies below the effective limit of class c.
    function automatic logic below_limit(input logic [CLASS_W-1:0] c,
                                         input logic [CMP_W-1:0] v,
                                         input vsp_cfg_t k);
        logic lim_ok;
        case (32'(c))
            0:       lim_ok = v < CMP_W'(k.limit[0]);
            1:       lim_ok = v < CMP_W'(k.limit[1]);
            2:       lim_ok = v < CMP_W'(k.limit[2]);
            default: lim_ok = 1'b1;
        endcase
        return lim_ok && (v < CMP_W'(SLOTS));
    endfunction

    vsp_slot_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (scan_addr),
        .rd_data (mem_rdata)
    );

    assign scan_addr = ADDR_W'(32'(cur_class_reg) * SLOTS + 32'(cur_slot_reg[SLOT_W-1:0]));
    assign match_key = (op_reg == OP_ADD) ? cfg.empty_marker : id_reg;
    assign match     = pend_valid_reg && (mem_rdata == match_key);
    assign bad_class = 32'(pool_class) >= CLASSES;
    assign count_rd  = counts_reg[work_class_reg];
    assign busy      = state_reg != FSM_IDLE;

    assign result.status      = res_status_reg;
    assign result.class_count = count_valid_reg ? count_rd : '0;
    assign result.has_space   = (op_reg == OP_QUERY) && count_valid_reg &&
                                below_limit(work_class_reg, CMP_W'(count_rd), cfg);
    assign result.slot_index  = res_slot_reg;
    assign result.hit_class   = res_hit_reg;

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        op_next          = op_reg;
        id_next          = id_reg;
        work_class_next  = work_class_reg;
        last_class_next  = last_class_reg;
        cur_class_next   = cur_class_reg;
        cur_slot_next    = cur_slot_reg;
        iter_active_next = iter_active_reg;
        pend_valid_next  = 1'b0;
        pend_class_next  = pend_class_reg;
        pend_slot_next   = pend_slot_reg;
        pend_addr_next   = pend_addr_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_hit_next     = res_hit_reg;
        count_valid_next = count_valid_reg;
        counts_next      = counts_reg;
        mem_we           = 1'b0;
        mem_waddr        = clr_addr_reg;
        mem_wdata        = ID_ALL_ONES;
        mem_re           = 1'b0;
        res_valid        = 1'b0;

        case (state_reg)
            FSM_CLEAR:
            begin
                mem_we = 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = FSM_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            FSM_IDLE:
            begin
                if (item_valid)
                begin
                    op_next          = op_t'(op);
                    id_next          = sound_id;
                    res_status_next  = STS_OK;
                    res_slot_next    = '0;
                    res_hit_next     = '0;
                    count_valid_next = 1'b0;
                    work_class_next  = CLASS_W'(pool_class);
                    cur_slot_next    = '0;
                    iter_active_next = 1'b1;
                    state_next       = FSM_DONE;
                    case (op_t'(op))
                        OP_QUERY:
                        begin
                            if (bad_class)
                            begin
                                res_status_next = STS_BAD_CLASS;
                            end
                            else
                            begin
                                count_valid_next = 1'b1;
                            end
                        end
                        OP_ADD:
                        begin
                            if (bad_class)
                            begin
                                res_status_next = STS_BAD_CLASS;
                            end
                            else
                            begin
                                cur_class_next  = CLASS_W'(pool_class);
                                last_class_next = CLASS_W'(pool_class);
                                state_next      = FSM_SCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (sound_id == cfg.empty_marker)
                            begin
                                res_status_next = STS_EMPTY_IGNORED;
                            end
                            else
                            begin
                                cur_class_next  = '0;
                                last_class_next = CLASS_W'(CLASSES - 1);
                                state_next      = FSM_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = FSM_DONE;
                        end
                    endcase
                end
            end

            FSM_SCAN:
            begin
                if (match)
                begin
                    mem_we           = 1'b1;
                    mem_waddr        = pend_addr_reg;
                    mem_wdata        = (op_reg == OP_ADD) ? id_reg : cfg.empty_marker;
                    res_slot_next    = SLOT_IDX_W'(pend_slot_reg);
                    res_hit_next     = CLASS_IDX_W'(pend_class_reg);
                    work_class_next  = pend_class_reg;
                    count_valid_next = 1'b1;
                    iter_active_next = 1'b0;
                    state_next       = FSM_WRITE;
                end
                else if (!iter_active_reg && !pend_valid_reg)
                begin
                    if (op_reg == OP_ADD)
                    begin
                        res_status_next  = STS_FULL;
                        count_valid_next = 1'b1;
                    end
                    else
                    begin
                        res_status_next = STS_NOT_FOUND;
                    end
                    state_next = FSM_DONE;
                end
                else if (iter_active_reg)
                begin
                    if (below_limit(cur_class_reg, CMP_W'(cur_slot_reg), cfg))
                    begin
                        mem_re          = 1'b1;
                        pend_valid_next = 1'b1;
                        pend_class_next = cur_class_reg;
                        pend_slot_next  = cur_slot_reg[SLOT_W-1:0];
                        pend_addr_next  = scan_addr;
                        cur_slot_next   = cur_slot_reg + 1'b1;
                    end
                    else if (cur_class_reg == last_class_reg)
                    begin
                        iter_active_next = 1'b0;
                    end
                    else
                    begin
                        cur_class_next = cur_class_reg + 1'b1;
                        cur_slot_next  = '0;
                    end
                end
            end

            FSM_WRITE:
            begin
                // Add saturates high, remove saturates at zero.
                if (op_reg == OP_ADD)
                begin
                    if (count_rd != COUNT_MAX)
                    begin
                        counts_next[work_class_reg] = count_rd + 1'b1;
                    end
                end
                else if (count_rd != '0)
                begin
                    counts_next[work_class_reg] = count_rd - 1'b1;
                end
                state_next = FSM_DONE;
            end

            FSM_DONE:
            begin
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= FSM_CLEAR;
            clr_addr_reg    <= '0;
            iter_active_reg <= 1'b0;
            pend_valid_reg  <= 1'b0;
            for (int i = 0; i < CLASSES; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            iter_active_reg <= iter_active_next;
            pend_valid_reg  <= pend_valid_next;
            counts_reg      <= counts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        id_reg          <= id_next;
        work_class_reg  <= work_class_next;
        last_class_reg  <= last_class_next;
        cur_class_reg   <= cur_class_next;
        cur_slot_reg    <= cur_slot_next;
        pend_class_reg  <= pend_class_next;
        pend_slot_reg   <= pend_slot_next;
        pend_addr_reg   <= pend_addr_next;
        res_status_reg  <= res_status_next;
        res_slot_reg    <= res_slot_next;
        res_hit_reg     <= res_hit_next;
        count_valid_reg <= count_valid_next;
    end

    // A slot write during the scan is always followed by the count update.
    a_match_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == FSM_SCAN) |=> state_reg == FSM_WRITE)
        else $error("scan wrote a slot without moving to the count update");

    // Outstanding reads exist only while scanning.
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> state_reg == FSM_SCAN)
        else $error("read outstanding outside the scan");

    // A successful add never lowers the class occupancy.
    a_add_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_WRITE && op_reg == OP_ADD) |=> count_rd >= $past(count_rd))
        else $error("add lowered the class count");

    // While the memory is being cleared no operation is accepted.
    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FSM_CLEAR) |=> (state_reg == FSM_CLEAR || state_reg == FSM_IDLE))
        else $error("left the clearing pass for an operation");

endmodule

### rtl/per_class_voice_slot_pool.sv
// ============================================================================
// per_class_voice_slot_pool: per-class identifier slot pool
// Register file, result word register and the pool sequencer.
// ============================================================================
// The pool holds CLASSES groups of SLOTS 32-bit identifier slots in one
// single-port-read memory, plus an occupancy count per class. After reset the
// block first sweeps the memory, writing all ones into one slot per cycle, so
// it takes no word until every slot is written; register writes are taken
// during that pass. A query's result word passes from the done state into the
// output register. An add reads the slots of its class one per cycle, from
// slot zero up to the class limit, through a single comparator, and stops at
// the first slot that holds the empty marker. A remove walks the classes in
// order and their slots the same way. One operation runs at a time and
// item_stall is high while it does; a finished result word sits in an output
// register, so a new word can be accepted while the previous result still
// waits on result_stall. Registers at byte address 4*i: 0 the 32-bit empty
// marker, 1..3 the 8-bit slot limits of classes zero to two. Limits above
// SLOTS act as SLOTS; classes above two use SLOTS. Change them only while the
// block is idle.
// ============================================================================
module per_class_voice_slot_pool
    import vsp_pkg::*;
#(
    parameter int SLOTS   = 128,
    parameter int CLASSES = 3
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,

    input  logic                   item_valid,
    output logic                   item_stall,
    input  logic [1:0]             op,
    input  logic [1:0]             pool_class,
    input  logic [ID_W-1:0]        sound_id,

    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [2:0]             status,
    output logic                   has_space,
    output logic [COUNT_W-1:0]     class_count,
    output logic [SLOT_IDX_W-1:0]  slot_index,
    output logic [CLASS_IDX_W-1:0] hit_class
);

    vsp_cfg_t    cfg_reg;
    logic        cfg_write;
    reg_idx_t    reg_idx;

    logic        busy;
    logic        res_ready;
    logic        res_valid;
    vsp_result_t result;

    logic        out_valid_reg;
    vsp_result_t out_reg;

    // The register file. The APB slave never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.empty_marker <= ID_ALL_ONES;
            for (int i = 0; i < NUM_LIMITS; i++)
            begin
                cfg_reg.limit[i] <= LIMIT_RESET;
            end
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_EMPTY_MARKER: cfg_reg.empty_marker <= pwdata;
                REG_LIMIT0:       cfg_reg.limit[0]     <= pwdata[LIMIT_W-1:0];
                REG_LIMIT1:       cfg_reg.limit[1]     <= pwdata[LIMIT_W-1:0];
                REG_LIMIT2:       cfg_reg.limit[2]     <= pwdata[LIMIT_W-1:0];
                default:          cfg_reg.empty_marker <= cfg_reg.empty_marker;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_EMPTY_MARKER: prdata = cfg_reg.empty_marker;
            REG_LIMIT0:       prdata = 32'(cfg_reg.limit[0]);
            REG_LIMIT1:       prdata = 32'(cfg_reg.limit[1]);
            REG_LIMIT2:       prdata = 32'(cfg_reg.limit[2]);
            default:          prdata = '0;
        endcase
    end

    // The sequencer owns the slot memory, the counts and the scan.
    vsp_seq #(
        .SLOTS   (SLOTS),
        .CLASSES (CLASSES)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .op         (op),
        .pool_class (pool_class),
        .sound_id   (sound_id),
        .busy       (busy),
        .res_ready  (res_ready),
        .res_valid  (res_valid),
        .result     (result)
    );

    assign item_stall = busy;

    // The output register takes a new result word when it is empty or when
    // its current word leaves in the same cycle.
    assign res_ready = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= result;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign has_space    = out_reg.has_space;
    assign class_count  = out_reg.class_count;
    assign slot_index   = out_reg.slot_index;
    assign hit_class    = out_reg.hit_class;

endmodule

### dv/vsp_pool_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// vsp_pool_checker: scoreboard for the per-class voice slot pool
// Watches the register port and both word channels. It keeps its own copy of
// the slot pools, the counts and the registers, predicts the answer word of
// every accepted request and compares it field by field with the answers in
// order.
// ============================================================================
module vsp_pool_checker
    import vsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [3:0]             paddr,
    input  logic [31:0]            pwdata,

    input  logic                   item_valid,
    input  logic                   item_stall,
    input  logic [1:0]             op,
    input  logic [1:0]             pool_class,
    input  logic [ID_W-1:0]        sound_id,

    input  logic                   result_valid,
    input  logic                   result_stall,
    input  logic [2:0]             status,
    input  logic                   has_space,
    input  logic [COUNT_W-1:0]     class_count,
    input  logic [SLOT_IDX_W-1:0]  slot_index,
    input  logic [CLASS_IDX_W-1:0] hit_class,

    output int                     mismatches,
    output int                     answers_due
);

    localparam int POOL_SLOTS   = 128;
    localparam int POOL_CLASSES = 3;

    logic [ID_W-1:0]    empty_id;
    logic [LIMIT_W-1:0] limit_reg [POOL_CLASSES];
    logic [ID_W-1:0]    slot_ids  [POOL_CLASSES][POOL_SLOTS];
    logic [COUNT_W-1:0] occupancy [POOL_CLASSES];
    vsp_result_t        answers_q [$];
    int                 error_tally = 0;

    task automatic flag_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        error_tally++;
    endtask

    // Limits above the pool size act as the pool size.
    function automatic int usable_slots(input int cls);
        int lim;
        lim = limit_reg[cls];
        return (lim > POOL_SLOTS) ? POOL_SLOTS : lim;
    endfunction

    // Applies one request to the shadow pools and returns its answer word.
    task automatic predict_answer(input op_t code, input int cls,
                                  input logic [ID_W-1:0] id, output vsp_result_t ans);
        bit found;
        int lim;
        ans = '0;
        ans.status = STS_OK;
        found = 1'b0;
        case (code)
            OP_QUERY: begin
                if (cls >= POOL_CLASSES) begin
                    ans.status = STS_BAD_CLASS;
                end else begin
                    ans.class_count = occupancy[cls];
                    ans.has_space = (int'(occupancy[cls]) < usable_slots(cls));
                end
            end
            OP_ADD: begin
                if (cls >= POOL_CLASSES) begin
                    ans.status = STS_BAD_CLASS;
                end else begin
                    lim = usable_slots(cls);
                    for (int i = 0; i < lim && !found; i++) begin
                        if (slot_ids[cls][i] == empty_id) begin
                            slot_ids[cls][i] = id;
                            if (occupancy[cls] != COUNT_MAX)
                                occupancy[cls] = occupancy[cls] + 1'b1;
                            ans.slot_index = SLOT_IDX_W'(i);
                            ans.hit_class = CLASS_IDX_W'(cls);
                            found = 1'b1;
                        end
                    end
                    ans.class_count = occupancy[cls];
                    if (!found)
                        ans.status = STS_FULL;
                end
            end
            OP_REMOVE: begin
                if (id == empty_id) begin
                    ans.status = STS_EMPTY_IGNORED;
                end else begin
                    for (int c = 0; c < POOL_CLASSES && !found; c++) begin
                        lim = usable_slots(c);
                        for (int i = 0; i < lim && !found; i++) begin
                            if (slot_ids[c][i] == id) begin
                                slot_ids[c][i] = empty_id;
                                if (occupancy[c] != '0)
                                    occupancy[c] = occupancy[c] - 1'b1;
                                ans.class_count = occupancy[c];
                                ans.slot_index = SLOT_IDX_W'(i);
                                ans.hit_class = CLASS_IDX_W'(c);
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found)
                        ans.status = STS_NOT_FOUND;
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk) begin : watch
        vsp_result_t want;
        if (!rst_n) begin
            empty_id = ID_ALL_ONES;
            for (int c = 0; c < POOL_CLASSES; c++) begin
                limit_reg[c] = LIMIT_RESET;
                occupancy[c] = '0;
                for (int s = 0; s < POOL_SLOTS; s++)
                    slot_ids[c][s] = ID_ALL_ONES;
            end
            answers_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_EMPTY_MARKER: empty_id     = pwdata;
                    REG_LIMIT0:       limit_reg[0] = pwdata[LIMIT_W-1:0];
                    REG_LIMIT1:       limit_reg[1] = pwdata[LIMIT_W-1:0];
                    REG_LIMIT2:       limit_reg[2] = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // Answers are taken before requests so that a word accepted at
            // this edge can never be matched against its own request.
            if (result_valid && !result_stall) begin
                if (answers_q.size() == 0) begin
                    flag_mismatch("answer word with no request outstanding");
                end else begin
                    want = answers_q.pop_front();
                    if (status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                status, want.status));
                    if (has_space !== want.has_space)
                        flag_mismatch($sformatf("has_space %0d, expected %0d",
                                                has_space, want.has_space));
                    if (class_count !== want.class_count)
                        flag_mismatch($sformatf("class_count %0d, expected %0d",
                                                class_count, want.class_count));
                    if (slot_index !== want.slot_index)
                        flag_mismatch($sformatf("slot_index %0d, expected %0d",
                                                slot_index, want.slot_index));
                    if (hit_class !== want.hit_class)
                        flag_mismatch($sformatf("hit_class %0d, expected %0d",
                                                hit_class, want.hit_class));
                end
            end
            if (item_valid && !item_stall) begin
                predict_answer(op_t'(op), int'(pool_class), sound_id, want);
                answers_q.push_back(want);
            end
        end
        mismatches  <= error_tally;
        answers_due <= answers_q.size();
    end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench of the per-class voice slot pool
// Drives requests and register writes into the pool, stalls the answer
// channel on a pattern of its own and leaves all checking to the scoreboard
// beside the block, whose mismatch count decides the verdict.
// ============================================================================
module tb;
    import vsp_pkg::*;

    // Pool class value with no pool behind it.
    localparam logic [1:0] CLASS_OUT_OF_RANGE = 2'd3;
    // A remove may walk every slot of every class.
    localparam int TAIL_CYCLES     = 400;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int RUN_LIMIT_NS    = 6_000_000;

    typedef enum {
        PLAIN,
        HOLD_OFF,
        DRAIN_MIDWAY
    } phase_twist_t;

    typedef enum {
        FLOW,
        LIGHT_STALL,
        HEAVY_STALL,
        TOGGLE
    } stall_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [3:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    logic                   item_valid = 1'b0;
    logic                   item_stall;
    logic [1:0]             op = '0;
    logic [1:0]             pool_class = '0;
    logic [ID_W-1:0]        sound_id = '0;

    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [2:0]             status;
    logic                   has_space;
    logic [COUNT_W-1:0]     class_count;
    logic [SLOT_IDX_W-1:0]  slot_index;
    logic [CLASS_IDX_W-1:0] hit_class;

    int                     mismatches;
    int                     answers_due;

    // Words left in the current burst of the sender.
    int                     burst_left = 0;
    // Each increment asks the answer side for one long hold-off.
    int                     hold_seq = 0;

    per_class_voice_slot_pool uut (.*);

    vsp_pool_checker scoreboard (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offers one request word and returns at the edge that accepts it. The
    // valid is left high so that a following word goes out back to back.
    task automatic send_word(input op_t code, input logic [1:0] cls,
                             input logic [ID_W-1:0] id);
        item_valid <= 1'b1;
        op         <= code;
        pool_class <= cls;
        sound_id   <= id;
        do @(posedge clk); while (item_stall);
    endtask

    // Sends a word as part of a burst. When a burst runs out, the sender may
    // go quiet for a random gap; a zero gap simply joins two bursts.
    task automatic offer(input op_t code, input logic [1:0] cls,
                         input logic [ID_W-1:0] id);
        int gap;
        send_word(code, cls, id);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 11);
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Stops sending and waits until every answer word has come back. Every
    // request yields exactly one answer, so the pool is idle from then on.
    task automatic drain();
        item_valid <= 1'b0;
        do @(posedge clk); while (answers_due != 0);
    endtask

    // One register write: a setup phase, then an access phase that lasts
    // until pready. The bus then goes quiet so that writes never overlap.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Brings the pool to rest and programs the marker and all three limits.
    task automatic set_pool(input logic [ID_W-1:0] marker, input int lim0,
                            input int lim1, input int lim2);
        drain();
        write_reg(REG_EMPTY_MARKER, marker);
        write_reg(REG_LIMIT0, 32'(lim0));
        write_reg(REG_LIMIT1, 32'(lim1));
        write_reg(REG_LIMIT2, 32'(lim2));
    endtask

    // Random traffic. Identifiers are drawn mostly from a small set of eight
    // so that removes find what adds stored and the pools fill up and drain.
    // The set holds the current marker, zero and all ones, which exercises
    // adds of the marker and stale slots after a marker change. One word in
    // ten carries a fresh random identifier, which a remove rarely finds.
    task automatic run_random(input int count, input logic [ID_W-1:0] marker,
                              input phase_twist_t twist);
        logic [ID_W-1:0] ids [8];
        int              pick;
        op_t             code;
        logic [1:0]      cls;
        logic [ID_W-1:0] id;
        for (int k = 0; k < 8; k++)
            ids[k] = $urandom;
        ids[5] = marker;
        ids[6] = '0;
        ids[7] = '1;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2) begin
                // Midway, either let the answers back up so that the pool
                // stalls its input, or go quiet until every answer is in.
                if (twist == HOLD_OFF)
                    hold_seq <= hold_seq + 1;
                else if (twist == DRAIN_MIDWAY)
                    drain();
            end
            pick = $urandom_range(0, 99);
            code = (pick < 40) ? OP_ADD : (pick < 75) ? OP_REMOVE :
                   (pick < 95) ? OP_QUERY : OP_NOP;
            cls  = ($urandom_range(0, 15) == 0) ? CLASS_OUT_OF_RANGE :
                   2'($urandom_range(0, 2));
            id   = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) :
                   ids[$urandom_range(0, 7)];
            offer(code, cls, id);
        end
    endtask

    // Answer side. It changes its stall behavior after each random stretch:
    // free flow, light and heavy random stalling, or a plain toggle. On
    // request it holds off for a long stretch, which backs up the output
    // register and then the input of the pool.
    initial
    begin : answer_side
        stall_mode_t mode;
        int          stretch;
        int          hold_seen;
        mode = FLOW;
        stretch = 0;
        hold_seen = 0;
        forever begin
            @(posedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end else begin
                if (stretch == 0) begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    stretch = $urandom_range(10, 150);
                end
                stretch--;
                case (mode)
                    FLOW:        result_stall <= 1'b0;
                    LIGHT_STALL: result_stall <= ($urandom_range(0, 3) == 0);
                    HEAVY_STALL: result_stall <= ($urandom_range(0, 3) != 0);
                    default:     result_stall <= ~result_stall;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        logic [ID_W-1:0] odd_marker;
        odd_marker = $urandom;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings. The first of them waits out
        // the clearing pass that follows reset.
        offer(OP_QUERY,  2'd0, '0);
        offer(OP_QUERY,  CLASS_OUT_OF_RANGE, '0);
        offer(OP_ADD,    CLASS_OUT_OF_RANGE, 32'd5);
        offer(OP_ADD,    2'd0, 32'h0000_0000);
        offer(OP_ADD,    2'd1, 32'hFFFF_FFFE);
        offer(OP_ADD,    2'd2, 32'h1234_5678);
        // Adding the marker counts, yet the slot still reads as empty, so
        // the next add lands in the same slot.
        offer(OP_ADD,    2'd2, ID_ALL_ONES);
        offer(OP_ADD,    2'd2, 32'hA5A5_A5A5);
        offer(OP_REMOVE, 2'd0, ID_ALL_ONES);
        offer(OP_REMOVE, 2'd0, 32'hDEAD_BEEF);
        // The class field plays no part in a remove, even out of range.
        offer(OP_REMOVE, CLASS_OUT_OF_RANGE, 32'hFFFF_FFFE);
        offer(OP_REMOVE, 2'd0, 32'h0000_0000);
        offer(OP_NOP,    CLASS_OUT_OF_RANGE, 32'h8000_0001);
        offer(OP_QUERY,  2'd2, '0);

        // Marker zero, a limit of zero, a limit beyond the pool size, and a
        // limit of one below slots that are already filled.
        set_pool('0, 0, 200, 1);
        offer(OP_QUERY,  2'd0, '0);
        offer(OP_ADD,    2'd0, 32'd7);
        offer(OP_ADD,    2'd2, 32'd9);
        // The old marker left in class one is now an ordinary identifier;
        // removing it finds a count of zero, which stays at zero.
        offer(OP_REMOVE, 2'd1, ID_ALL_ONES);
        offer(OP_ADD,    2'd1, 32'h0000_0000);
        offer(OP_REMOVE, 2'd1, 32'h0000_0000);
        offer(OP_QUERY,  2'd1, '0);
        // Stored in slot one of class two, which the limit of one now hides.
        offer(OP_REMOVE, 2'd0, 32'hA5A5_A5A5);

        // Random phases across the settings, extremes included.
        set_pool(ID_ALL_ONES, 128, 128, 128);
        run_random(260, ID_ALL_ONES, HOLD_OFF);
        set_pool(ID_ALL_ONES, 1, 2, 4);
        run_random(220, ID_ALL_ONES, PLAIN);
        set_pool(ID_ALL_ONES, 0, 200, 8);
        run_random(200, ID_ALL_ONES, PLAIN);
        set_pool('0, 16, 16, 16);
        run_random(200, '0, DRAIN_MIDWAY);
        set_pool(odd_marker, 3, 5, 128);
        run_random(140, odd_marker, PLAIN);

        // Repeated adds of the marker pile up in one slot until the count
        // of class one saturates.
        set_pool(ID_ALL_ONES, 128, 128, 128);
        for (int k = 0; k < 260; k++)
            offer(OP_ADD, 2'd1, ID_ALL_ONES);
        offer(OP_QUERY, 2'd1, '0);

        set_pool(ID_ALL_ONES, 128, 1, 128);
        run_random(260, ID_ALL_ONES, HOLD_OFF);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : watchdog
        #RUN_LIMIT_NS;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
rtl/vsp_pkg.sv
rtl/vsp_slot_mem.sv
rtl/vsp_seq.sv
rtl/per_class_voice_slot_pool.sv
dv/vsp_pool_checker.sv
dv/tb.sv
